@@ hw/rtl/piaw_pkg.sv @@
package piaw_pkg;

  // field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_BITS  = 12;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 16;
  localparam int INTEG_W    = 40;
  localparam int ERR_W      = SAMPLE_W + 1;
  // multiplicand must hold the excess over the limit: integrator plus p term
  localparam int MCAND_W    = INTEG_W + 2;
  localparam int PROD_W     = MCAND_W + GAIN_W;
  localparam int WIDE_W     = INTEG_W + 8;
  localparam int CNT_W      = $clog2(GAIN_W);
  localparam int HIT_W      = 2;

  // port widths
  localparam int IN_DATA_W  = 2 * SAMPLE_W;
  localparam int OUT_DATA_W = SAMPLE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_AW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW  = 3'd5;

  // mode codes
  localparam logic MODE_BACKCALC = 1'b0;
  localparam logic MODE_CLAMP    = 1'b1;

  // limit flag codes
  localparam logic [HIT_W-1:0] HIT_NONE = 2'd0;
  localparam logic [HIT_W-1:0] HIT_HIGH = 2'd1;
  localparam logic [HIT_W-1:0] HIT_LOW  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_SUM,
    S_USUM,
    S_CMP,
    S_EXC,
    S_MUL2,
    S_UPD,
    S_DONE
  } state_t;

  // saturate a wide value to the signed integrator range
  function automatic logic signed [INTEG_W-1:0] sat_integ(
    input logic signed [WIDE_W-1:0] v
  );
    logic [WIDE_W-INTEG_W:0] top;
    top = v[WIDE_W-1:INTEG_W-1];
    if (top == '0 || top == '1) begin
      sat_integ = v[INTEG_W-1:0];
    end else if (v[WIDE_W-1]) begin
      sat_integ = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      sat_integ = {1'b0, {(INTEG_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ hw/rtl/piaw_smul.sv @@
// shift-add multiplier, one gain bit per cycle, msb first
module piaw_smul (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic signed [piaw_pkg::MCAND_W-1:0]   mcand,
  input  logic        [piaw_pkg::GAIN_W-1:0]    mult,
  output logic                                  done,
  output logic signed [piaw_pkg::PROD_W-1:0]    prod
);

  logic                                busy_r;
  logic                                done_r;
  logic [piaw_pkg::CNT_W-1:0]          cnt_r;
  logic [piaw_pkg::GAIN_W-1:0]         mult_r;
  logic signed [piaw_pkg::MCAND_W-1:0] mcand_r;
  logic signed [piaw_pkg::PROD_W-1:0]  acc_r;
  logic signed [piaw_pkg::PROD_W-1:0]  addend;

  always_comb begin
    if (mult_r[piaw_pkg::GAIN_W-1]) begin
      addend = {{piaw_pkg::GAIN_W{mcand_r[piaw_pkg::MCAND_W-1]}}, mcand_r};
    end else begin
      addend = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == piaw_pkg::CNT_W'(piaw_pkg::GAIN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mult_r  <= mult;
      mcand_r <= mcand;
      acc_r   <= '0;
    end else if (busy_r) begin
      mult_r <= {mult_r[piaw_pkg::GAIN_W-2:0], 1'b0};
      acc_r  <= {acc_r[piaw_pkg::PROD_W-2:0], 1'b0} + addend;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ hw/rtl/pi_controller_anti_windup.sv @@
// channel  dir  signals                         contents
// in       in   in_tvalid/in_tready/in_tdata    reference [15:0], measured [31:16]
// out      out  out_tvalid/out_tready/out_tdata drive [15:0]
//                out_tuser                      limit_hit [1:0]
// cfg      in   cfg_valid/cfg_ready/cfg_index   register index, write data in cfg_data
//
// one request at a time; the time per request is set by the 16-step serial
// multiplier, run once in clamping mode, or twice in back-calculation mode
// for the anti-windup product
// rst_n is synchronous: gains, limits and mode go to defaults, integrator and
// previous error to zero
// a finished result sits in the output register; the next request is taken
// while it waits, and the block stalls only before writing the following result
// cfg_ready is always high
module pi_controller_anti_windup (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // reference [15:0], measured [31:16]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [piaw_pkg::IN_DATA_W-1:0]       in_tdata,
  // drive [15:0]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [piaw_pkg::OUT_DATA_W-1:0]      out_tdata,
  // limit_hit [1:0]
  output logic [piaw_pkg::HIT_W-1:0]           out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [piaw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [piaw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // configuration registers
  logic                                  mode_r;
  logic [piaw_pkg::GAIN_W-1:0]           gain_p_r;
  logic [piaw_pkg::GAIN_W-1:0]           gain_i_r;
  logic [piaw_pkg::GAIN_W-1:0]           gain_aw_r;
  logic [piaw_pkg::LIMIT_W-1:0]          limit_high_r;
  logic [piaw_pkg::LIMIT_W-1:0]          limit_low_r;

  // controller state
  logic signed [piaw_pkg::INTEG_W-1:0]   integ_r;
  logic signed [piaw_pkg::ERR_W-1:0]     prev_err_r;

  // datapath registers
  logic signed [piaw_pkg::WIDE_W-1:0]    pterm_r;
  logic signed [piaw_pkg::WIDE_W-1:0]    aux_r;
  logic signed [piaw_pkg::WIDE_W-1:0]    u_r;
  logic signed [piaw_pkg::INTEG_W-1:0]   d_r;
  logic signed [piaw_pkg::WIDE_W-1:0]    clamped_r;
  logic signed [piaw_pkg::WIDE_W-1:0]    tmp_r;
  logic signed [piaw_pkg::WIDE_W-1:0]    aw_r;
  logic [piaw_pkg::HIT_W-1:0]            flag_r;
  logic                                  plt_r;
  logic                                  pgt_r;

  // output register
  logic                                  out_valid_r;
  logic [piaw_pkg::OUT_DATA_W-1:0]       out_drive_r;
  logic [piaw_pkg::HIT_W-1:0]            out_hit_r;

  piaw_pkg::state_t state_r, state_nxt;

  logic                                  in_acc;
  logic                                  out_load;
  logic                                  start_a;
  logic                                  start_b;
  logic                                  done_a;
  logic                                  done_b;
  logic signed [piaw_pkg::PROD_W-1:0]    prod_a;
  logic signed [piaw_pkg::PROD_W-1:0]    prod_b;
  logic signed [piaw_pkg::MCAND_W-1:0]   mcand_a;
  logic signed [piaw_pkg::MCAND_W-1:0]   mcand_b;
  logic        [piaw_pkg::GAIN_W-1:0]    mult_b;
  logic signed [piaw_pkg::ERR_W-1:0]     err;
  logic signed [piaw_pkg::ERR_W:0]       err_sum;
  logic signed [piaw_pkg::WIDE_W-1:0]    hi_w;
  logic signed [piaw_pkg::WIDE_W-1:0]    lo_w;
  logic signed [piaw_pkg::WIDE_W-1:0]    integ_w;
  logic signed [piaw_pkg::WIDE_W-1:0]    exc_w;

  // error at full precision, one bit wider than the samples
  assign err = {in_tdata[piaw_pkg::SAMPLE_W-1], in_tdata[piaw_pkg::SAMPLE_W-1:0]}
             - {in_tdata[piaw_pkg::IN_DATA_W-1],
                in_tdata[piaw_pkg::IN_DATA_W-1:piaw_pkg::SAMPLE_W]};
  assign err_sum = {err[piaw_pkg::ERR_W-1], err}
                 + {prev_err_r[piaw_pkg::ERR_W-1], prev_err_r};

  // limits scaled to integrator fraction bits
  assign hi_w = $signed({{(piaw_pkg::WIDE_W-piaw_pkg::LIMIT_W-piaw_pkg::FRAC_BITS)
                          {limit_high_r[piaw_pkg::LIMIT_W-1]}},
                         limit_high_r, {piaw_pkg::FRAC_BITS{1'b0}}});
  assign lo_w = $signed({{(piaw_pkg::WIDE_W-piaw_pkg::LIMIT_W-piaw_pkg::FRAC_BITS)
                          {limit_low_r[piaw_pkg::LIMIT_W-1]}},
                         limit_low_r, {piaw_pkg::FRAC_BITS{1'b0}}});
  assign integ_w = $signed({{(piaw_pkg::WIDE_W-piaw_pkg::INTEG_W)
                             {integ_r[piaw_pkg::INTEG_W-1]}}, integ_r});

  // excess over the applied limit, feeds the anti-windup product
  assign exc_w = u_r - clamped_r;

  assign in_tready = (state_r == piaw_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == piaw_pkg::S_DONE) && (!out_valid_r || out_tready);

  // multiplier a: p term; multiplier b: i term, then anti-windup term
  assign start_a = in_acc;
  assign mcand_a = {{(piaw_pkg::MCAND_W-piaw_pkg::ERR_W){err[piaw_pkg::ERR_W-1]}}, err};

  always_comb begin
    if (state_r == piaw_pkg::S_EXC) begin
      mcand_b = exc_w[piaw_pkg::MCAND_W-1:0];
      mult_b  = gain_aw_r;
    end else if (mode_r == piaw_pkg::MODE_CLAMP) begin
      mcand_b = {{(piaw_pkg::MCAND_W-piaw_pkg::ERR_W-1){err_sum[piaw_pkg::ERR_W]}}, err_sum};
      mult_b  = gain_i_r;
    end else begin
      mcand_b = mcand_a;
      mult_b  = gain_i_r;
    end
  end

  piaw_smul u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_a),
    .mcand (mcand_a),
    .mult  (gain_p_r),
    .done  (done_a),
    .prod  (prod_a)
  );

  piaw_smul u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_b),
    .mcand (mcand_b),
    .mult  (mult_b),
    .done  (done_b),
    .prod  (prod_b)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= piaw_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    start_b   = 1'b0;
    unique case (state_r)
      piaw_pkg::S_IDLE: begin
        if (in_acc) begin
          start_b   = 1'b1;
          state_nxt = piaw_pkg::S_MUL1;
        end
      end
      piaw_pkg::S_MUL1: begin
        if (done_a) begin
          state_nxt = piaw_pkg::S_SUM;
        end
      end
      piaw_pkg::S_SUM: begin
        // clamping mode needs one more add for the sum of p and d
        if (mode_r == piaw_pkg::MODE_CLAMP) begin
          state_nxt = piaw_pkg::S_USUM;
        end else begin
          state_nxt = piaw_pkg::S_CMP;
        end
      end
      piaw_pkg::S_USUM: begin
        state_nxt = piaw_pkg::S_CMP;
      end
      piaw_pkg::S_CMP: begin
        if (mode_r == piaw_pkg::MODE_CLAMP) begin
          state_nxt = piaw_pkg::S_UPD;
        end else begin
          state_nxt = piaw_pkg::S_EXC;
        end
      end
      piaw_pkg::S_EXC: begin
        start_b   = 1'b1;
        state_nxt = piaw_pkg::S_MUL2;
      end
      piaw_pkg::S_MUL2: begin
        if (done_b) begin
          state_nxt = piaw_pkg::S_UPD;
        end
      end
      piaw_pkg::S_UPD: begin
        state_nxt = piaw_pkg::S_DONE;
      end
      piaw_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = piaw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = piaw_pkg::S_IDLE;
      end
    endcase
  end

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= piaw_pkg::MODE_BACKCALC;
      gain_p_r     <= piaw_pkg::GAIN_W'(1 << piaw_pkg::FRAC_BITS);
      gain_i_r     <= '0;
      gain_aw_r    <= '0;
      limit_high_r <= {1'b0, {(piaw_pkg::LIMIT_W-1){1'b1}}};
      limit_low_r  <= {1'b1, {(piaw_pkg::LIMIT_W-1){1'b0}}};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        piaw_pkg::REG_MODE:       mode_r       <= cfg_data[0];
        piaw_pkg::REG_GAIN_P:     gain_p_r     <= cfg_data[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_GAIN_I:     gain_i_r     <= cfg_data[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_GAIN_AW:    gain_aw_r    <= cfg_data[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_LIMIT_HIGH: limit_high_r <= cfg_data[piaw_pkg::LIMIT_W-1:0];
        piaw_pkg::REG_LIMIT_LOW:  limit_low_r  <= cfg_data[piaw_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // controller state: integrator and previous error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r    <= '0;
      prev_err_r <= '0;
    end else begin
      // in clamping mode the old previous error goes into multiplier b on the same edge
      if (in_acc) begin
        prev_err_r <= err;
      end
      if (state_r == piaw_pkg::S_UPD) begin
        if (mode_r == piaw_pkg::MODE_CLAMP) begin
          case (flag_r)
            piaw_pkg::HIT_HIGH: begin
              if (plt_r) begin
                integ_r <= piaw_pkg::sat_integ(hi_w - pterm_r);
              end
            end
            piaw_pkg::HIT_LOW: begin
              if (pgt_r) begin
                integ_r <= piaw_pkg::sat_integ(lo_w - pterm_r);
              end
            end
            default: integ_r <= d_r;
          endcase
        end else begin
          integ_r <= piaw_pkg::sat_integ(tmp_r - aw_r);
        end
      end
    end
  end

  // arithmetic pipeline, one add or compare per step
  always_ff @(posedge clk) begin
    if (state_r == piaw_pkg::S_MUL1 && done_a) begin
      pterm_r <= prod_a[piaw_pkg::WIDE_W-1:0];
      // clamping mode: half of gain_i * (e + previous e), floor
      if (mode_r == piaw_pkg::MODE_CLAMP) begin
        aux_r <= prod_b[piaw_pkg::WIDE_W:1];
      end else begin
        aux_r <= prod_b[piaw_pkg::WIDE_W-1:0];
      end
    end
    if (state_r == piaw_pkg::S_SUM) begin
      if (mode_r == piaw_pkg::MODE_CLAMP) begin
        d_r <= piaw_pkg::sat_integ(integ_w + aux_r);
      end else begin
        u_r <= integ_w + pterm_r;
      end
    end
    if (state_r == piaw_pkg::S_USUM) begin
      u_r <= pterm_r + $signed({{(piaw_pkg::WIDE_W-piaw_pkg::INTEG_W)
                                 {d_r[piaw_pkg::INTEG_W-1]}}, d_r});
    end
    if (state_r == piaw_pkg::S_CMP) begin
      // upper test first; with crossed limits the upper limit wins when both tests hold
      if (u_r > hi_w) begin
        clamped_r <= hi_w;
        flag_r    <= piaw_pkg::HIT_HIGH;
      end else if (u_r < lo_w) begin
        clamped_r <= lo_w;
        flag_r    <= piaw_pkg::HIT_LOW;
      end else begin
        clamped_r <= u_r;
        flag_r    <= piaw_pkg::HIT_NONE;
      end
      plt_r <= (pterm_r < hi_w);
      pgt_r <= (pterm_r > lo_w);
    end
    if (state_r == piaw_pkg::S_MUL2 && done_b) begin
      tmp_r <= integ_w + aux_r;
      aw_r  <= $signed({{(piaw_pkg::WIDE_W-piaw_pkg::PROD_W+piaw_pkg::FRAC_BITS)
                         {prod_b[piaw_pkg::PROD_W-1]}},
                        prod_b[piaw_pkg::PROD_W-1:piaw_pkg::FRAC_BITS]});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      // floor shift of the clamped value, taken as a bit slice
      out_drive_r <= clamped_r[piaw_pkg::FRAC_BITS +: piaw_pkg::SAMPLE_W];
      out_hit_r   <= flag_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_hit_r;

  // checks
  a_flag_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == piaw_pkg::HIT_NONE || out_tuser == piaw_pkg::HIT_HIGH ||
                    out_tuser == piaw_pkg::HIT_LOW))
    else $error("limit flag carries an unused code");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == piaw_pkg::S_MUL1))
    else $error("accepted request did not start the multipliers");

  a_mul_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == piaw_pkg::S_MUL1) |-> (done_a == done_b))
    else $error("p and i products finished apart");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == piaw_pkg::S_DONE))
    else $error("result raised outside the finishing step");

endmodule
